// ----- rtl/u8d_pkg.sv -----
package u8d_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 32;
  localparam int unsigned CP_W            = 21;
  localparam int unsigned LEN_W           = 3;
  localparam int unsigned OUT_OFF_W       = 32;

  localparam logic [CP_W-1:0] CP_MAX   = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO  = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI  = 21'h00DFFF;
  localparam logic [CP_W-1:0] MIN_LEN2 = 21'h000080;
  localparam logic [CP_W-1:0] MIN_LEN3 = 21'h000800;
  localparam logic [CP_W-1:0] MIN_LEN4 = 21'h010000;

  localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
  localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
  localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
  localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

  // Decoder state apart from the offset counters, whose width is a parameter
  typedef struct packed {
    logic [1:0]       pending;
    logic [CP_W-1:0]  value;
    logic [LEN_W-1:0] len;
    logic             err;
  } dec_state_t;

  typedef struct packed {
    logic                 status;
    logic [CP_W-1:0]      code_point;
    logic [OUT_OFF_W-1:0] start_offset;
    logic [LEN_W-1:0]     byte_length;
    logic                 end_of_text;
  } dec_result_t;

  function automatic logic value_ok(logic [CP_W-1:0] v, logic [LEN_W-1:0] len);
    logic [CP_W-1:0] smallest;
    smallest = '0;
    unique case (len)
      LEN_TWO:   smallest = MIN_LEN2;
      LEN_THREE: smallest = MIN_LEN3;
      LEN_FOUR:  smallest = MIN_LEN4;
      default:   smallest = '0;
    endcase
    return (v >= smallest) && !((v >= SURR_LO) && (v <= SURR_HI)) && (v <= CP_MAX);
  endfunction

endpackage

// ----- rtl/utf8_validating_decoder_core.sv -----
// Strict UTF-8 decoder, one byte per transfer.
// Input channel: in_text_byte with in_final_byte marking the last byte of a
// text; a transfer happens when in_valid is high and in_stall is low.
// Output channel: one result per completed sequence (code point, offset of
// its lead byte, length), or a single result with out_status set at the final
// byte of a text that was rejected. Bytes after an error give nothing.
// Throughput: one byte per cycle while out_stall does not hold the output. A
// sequence's last byte is taken into the input register, and the decode step
// then writes its result into the result register, which presents it.
// A result waits in the output register while out_stall is high; the input
// register then fills and in_stall rises, holding further bytes back.
// Reset (rst_n low, synchronous) empties both registers and returns the
// decoder to the start of a text at offset zero. Every final byte returns
// the decoder there after its result. Offsets wrap at 2^OFFSET_BITS.
module utf8_validating_decoder_core #(
  parameter int unsigned OFFSET_BITS = u8d_pkg::OFFSET_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_text_byte,
  input  logic                          in_final_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_status,
  output logic [u8d_pkg::CP_W-1:0]      out_code_point,
  output logic [u8d_pkg::OUT_OFF_W-1:0] out_start_offset,
  output logic [u8d_pkg::LEN_W-1:0]     out_byte_length,
  output logic                          out_end_of_text
);
  import u8d_pkg::*;

  logic                   in_valid_r;
  logic [7:0]             in_text_byte_r;
  logic                   in_final_byte_r;
  dec_state_t             st_r, st_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic                   out_valid_r;
  dec_result_t            res_r, res_nxt;
  logic                   emit;
  logic                   adv;
  logic                   in_take;

  // advance the held byte when the result register is free or draining
  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  u8d_step #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_step (
    .st        (st_r),
    .pos       (pos_r),
    .start     (start_r),
    .text_byte (in_text_byte_r),
    .final_byte(in_final_byte_r),
    .st_nxt    (st_nxt),
    .pos_nxt   (pos_nxt),
    .start_nxt (start_nxt),
    .emit      (emit),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
      pos_r       <= '0;
      start_r     <= '0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (adv) begin
        in_valid_r <= 1'b0;
      end
      if (adv) begin
        st_r        <= st_nxt;
        pos_r       <= pos_nxt;
        start_r     <= start_nxt;
        out_valid_r <= emit;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_text_byte_r  <= in_text_byte;
      in_final_byte_r <= in_final_byte;
    end
    if (adv && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = res_r.status;
  assign out_code_point   = res_r.code_point;
  assign out_start_offset = res_r.start_offset;
  assign out_byte_length  = res_r.byte_length;
  assign out_end_of_text  = res_r.end_of_text;

  a_invalid_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.status |->
      (res_r.code_point == '0) && (res_r.byte_length == '0) && res_r.end_of_text)
    else $error("rejection result carries non-zero fields");

  a_scalar_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.status |->
      (res_r.code_point <= CP_MAX) &&
      !((res_r.code_point >= SURR_LO) && (res_r.code_point <= SURR_HI)) &&
      (res_r.byte_length != '0) && (res_r.byte_length <= LEN_FOUR))
    else $error("decoded result outside the scalar range");

  a_final_restart: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_final_byte_r |=>
      (pos_r == '0) && (st_r.pending == 2'd0) && !st_r.err)
    else $error("decoder not back at text start after final byte");

  a_silent_after_error: assert property (@(posedge clk) disable iff (!rst_n)
    adv && st_r.err && !in_final_byte_r |=> !out_valid_r)
    else $error("result given for a text already rejected");

endmodule

// ----- rtl/u8d_step.sv -----
module u8d_step #(
  parameter int unsigned OFFSET_BITS = u8d_pkg::OFFSET_BITS_DEF
) (
  input  u8d_pkg::dec_state_t  st,
  input  logic [OFFSET_BITS-1:0] pos,
  input  logic [OFFSET_BITS-1:0] start,
  input  logic [7:0]           text_byte,
  input  logic                 final_byte,
  output u8d_pkg::dec_state_t  st_nxt,
  output logic [OFFSET_BITS-1:0] pos_nxt,
  output logic [OFFSET_BITS-1:0] start_nxt,
  output logic                 emit,
  output u8d_pkg::dec_result_t res
);
  import u8d_pkg::*;

  logic       done;
  logic       invalid;
  logic [63:0] start_ext;

  always_comb begin
    st_nxt    = st;
    pos_nxt   = pos + 1'b1;
    start_nxt = start;
    done      = 1'b0;

    if (!st.err) begin
      if (st.pending == 2'd0) begin
        start_nxt = pos;
        priority if (!text_byte[7]) begin
          st_nxt.value = CP_W'(text_byte);
          st_nxt.len   = LEN_ONE;
          done         = 1'b1;
        end else if (text_byte[7:5] == 3'b110) begin
          st_nxt.value   = CP_W'(text_byte[4:0]);
          st_nxt.len     = LEN_TWO;
          st_nxt.pending = 2'd1;
        end else if (text_byte[7:4] == 4'b1110) begin
          st_nxt.value   = CP_W'(text_byte[3:0]);
          st_nxt.len     = LEN_THREE;
          st_nxt.pending = 2'd2;
        end else if (text_byte[7:3] == 5'b11110) begin
          st_nxt.value   = CP_W'(text_byte[2:0]);
          st_nxt.len     = LEN_FOUR;
          st_nxt.pending = 2'd3;
        end else begin
          st_nxt.err = 1'b1;
        end
      end else if (text_byte[7:6] != 2'b10) begin
        st_nxt.err = 1'b1;
      end else begin
        st_nxt.value   = {st.value[CP_W-7:0], text_byte[5:0]};
        st_nxt.pending = st.pending - 2'd1;
        done           = (st.pending == 2'd1);
      end
      // reject overlong forms, surrogates and values beyond the last plane
      if (done && !value_ok(st_nxt.value, st_nxt.len)) begin
        st_nxt.err = 1'b1;
        done       = 1'b0;
      end
    end

    if (final_byte && !st_nxt.err && (st_nxt.pending != 2'd0)) begin
      st_nxt.err = 1'b1;
    end

    invalid   = final_byte && st_nxt.err;
    emit      = invalid || done;
    start_ext = 64'(start_nxt);

    res.status       = invalid;
    res.code_point   = invalid ? '0 : st_nxt.value;
    res.start_offset = invalid ? '0 : start_ext[OUT_OFF_W-1:0];
    res.byte_length  = invalid ? '0 : st_nxt.len;
    res.end_of_text  = final_byte;

    // a final byte starts the next text afresh at offset zero
    if (final_byte) begin
      st_nxt    = '0;
      pos_nxt   = '0;
      start_nxt = '0;
    end
  end

endmodule
